@@ sv/etm_pkg.sv @@
// ----------------------------------------------------------------------------
// Ethiopic transliteration mapper package
// Shared types, key codes, vowel codes and the fixed glyph table.
// ----------------------------------------------------------------------------
`default_nettype none

package etm_pkg;

   localparam int unsigned LETTER_COUNT_DEFAULT = 26;
   localparam int unsigned TABLE_ROWS           = 26;

   localparam logic [7:0] KEY_SPACE = 8'h20;
   localparam logic [7:0] KEY_A     = 8'h41;
   localparam logic [7:0] KEY_E     = 8'h45;
   localparam logic [7:0] KEY_I     = 8'h49;
   localparam logic [7:0] KEY_O     = 8'h4F;
   localparam logic [7:0] KEY_U     = 8'h55;

   localparam logic [2:0] VOWEL_NONE = 3'd0;
   localparam logic [2:0] VOWEL_A    = 3'd1;
   localparam logic [2:0] VOWEL_E    = 3'd2;
   localparam logic [2:0] VOWEL_I    = 3'd3;
   localparam logic [2:0] VOWEL_O    = 3'd4;
   localparam logic [2:0] VOWEL_U    = 3'd5;

   localparam logic [3:0] ORDER_CONSONANT = 4'd5;
   localparam logic [3:0] ORDER_PAIR_EI   = 4'd4;

   localparam logic [1:0] BS_NEW     = 2'd1;
   localparam logic [1:0] BS_REPLACE = 2'd2;

   typedef struct packed {
      logic [7:0] key_code;
      logic       shift_down;
   } etm_key_type;

   typedef struct packed {
      logic        consumed;
      logic [1:0]  backspaces;
      logic [15:0] code_point;
   } etm_result_type;

   typedef struct packed {
      logic [15:0] base;
      logic [3:0]  labial;
   } etm_glyph_type;

   function automatic etm_glyph_type glyph_entry(input logic [15:0] base,
                                                 input logic [3:0] labial);
      etm_glyph_type g;
      g.base   = base;
      g.labial = labial;
      return g;
   endfunction

   function automatic etm_glyph_type glyph_lookup(input logic [4:0] row,
                                                  input logic shift);
      etm_glyph_type g;
      case (row)
         5'd0:  g = shift ? glyph_entry(16'h12A3, 4'd7)  : glyph_entry(16'h12A0, 4'd7);
         5'd1:  g = glyph_entry(16'h1260, 4'd7);
         5'd2:  g = shift ? glyph_entry(16'h1328, 4'd7)  : glyph_entry(16'h1278, 4'd7);
         5'd3:  g = shift ? glyph_entry(16'h12F8, 4'd7)  : glyph_entry(16'h12F0, 4'd7);
         5'd4:  g = shift ? glyph_entry(16'h12A7, 4'd7)  : glyph_entry(16'h12A5, 4'd7);
         5'd5:  g = shift ? glyph_entry(16'h1280, 4'd11) : glyph_entry(16'h1348, 4'd7);
         5'd6:  g = shift ? glyph_entry(16'h1318, 4'd7)  : glyph_entry(16'h1308, 4'd11);
         5'd7:  g = shift ? glyph_entry(16'h1210, 4'd7)  : glyph_entry(16'h1200, 4'd7);
         5'd8:  g = shift ? glyph_entry(16'h12A4, 4'd7)  : glyph_entry(16'h12A2, 4'd7);
         5'd9:  g = glyph_entry(16'h1300, 4'd7);
         5'd10: g = shift ? glyph_entry(16'h12B8, 4'd11) : glyph_entry(16'h12A8, 4'd11);
         5'd11: g = glyph_entry(16'h1208, 4'd7);
         5'd12: g = glyph_entry(16'h1218, 4'd7);
         5'd13: g = shift ? glyph_entry(16'h1298, 4'd7)  : glyph_entry(16'h1290, 4'd7);
         5'd14: g = glyph_entry(16'h12A6, 4'd7);
         5'd15: g = shift ? glyph_entry(16'h1330, 4'd7)  : glyph_entry(16'h1350, 4'd7);
         5'd16: g = shift ? glyph_entry(16'h1250, 4'd11) : glyph_entry(16'h1240, 4'd11);
         5'd17: g = shift ? glyph_entry(16'h1340, 4'd7)  : glyph_entry(16'h1228, 4'd7);
         5'd18: g = shift ? glyph_entry(16'h1338, 4'd7)  : glyph_entry(16'h1230, 4'd7);
         5'd19: g = shift ? glyph_entry(16'h1320, 4'd7)  : glyph_entry(16'h1270, 4'd7);
         5'd20: g = glyph_entry(16'h12A1, 4'd7);
         5'd21: g = glyph_entry(16'h1268, 4'd7);
         5'd22: g = shift ? glyph_entry(16'h1220, 4'd7)  : glyph_entry(16'h12C8, 4'd7);
         5'd23: g = shift ? glyph_entry(16'h12D0, 4'd7)  : glyph_entry(16'h1238, 4'd7);
         5'd24: g = glyph_entry(16'h12E8, 4'd7);
         5'd25: g = shift ? glyph_entry(16'h12E0, 4'd7)  : glyph_entry(16'h12D8, 4'd7);
         default: g = glyph_entry(16'h0000, 4'd0);
      endcase
      return g;
   endfunction

   function automatic logic [2:0] vowel_code(input logic [7:0] key);
      logic [2:0] v;
      case (key)
         KEY_A:   v = VOWEL_A;
         KEY_E:   v = VOWEL_E;
         KEY_I:   v = VOWEL_I;
         KEY_O:   v = VOWEL_O;
         KEY_U:   v = VOWEL_U;
         default: v = VOWEL_NONE;
      endcase
      return v;
   endfunction

   function automatic logic [3:0] vowel_order(input logic [2:0] v);
      logic [3:0] o;
      case (v)
         VOWEL_A: o = 4'd3;
         VOWEL_E: o = 4'd0;
         VOWEL_I: o = 4'd2;
         VOWEL_O: o = 4'd6;
         VOWEL_U: o = 4'd1;
         default: o = ORDER_CONSONANT;
      endcase
      return o;
   endfunction

endpackage

`default_nettype wire

@@ sv/etm_mapper.sv @@
// ----------------------------------------------------------------------------
// Ethiopic transliteration mapper core
// Keystroke history registers and the single-pass glyph mapping logic.
// ----------------------------------------------------------------------------
`default_nettype none

module etm_mapper #(
   parameter int unsigned LETTER_COUNT = etm_pkg::LETTER_COUNT_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire etm_pkg::etm_key_type    key,
   output etm_pkg::etm_result_type      result
);
   import etm_pkg::*;

   logic        have_consonant_ff, have_consonant_in;
   logic [2:0]  last_vowel_ff, last_vowel_in;
   logic [15:0] held_base_ff, held_base_in;
   logic [3:0]  held_labial_ff, held_labial_in;

   logic [7:0]    letter_idx;
   logic          is_letter;
   logic [2:0]    vowel;
   etm_glyph_type glyph;
   logic          pair_ei;
   logic          pair_aa;
   logic          keep_consonant;
   logic [3:0]    order;

   assign letter_idx = key.key_code - KEY_A;
   assign is_letter  = (key.key_code >= KEY_A) && (letter_idx < 8'(LETTER_COUNT)) &&
                       (letter_idx < 8'(TABLE_ROWS));
   assign glyph      = glyph_lookup(letter_idx[4:0], key.shift_down);
   assign vowel      = vowel_code(key.key_code);

   assign pair_ei = ((last_vowel_ff == VOWEL_E) && (vowel == VOWEL_I)) ||
                    ((last_vowel_ff == VOWEL_I) && (vowel == VOWEL_E));
   assign pair_aa = (last_vowel_ff == VOWEL_A) && (vowel == VOWEL_A);
   assign keep_consonant = have_consonant_ff &&
                           !((last_vowel_ff != VOWEL_NONE) && !pair_ei && !pair_aa);

   always_comb begin
      if (pair_ei) begin
         order = ORDER_PAIR_EI;
      end else if (pair_aa) begin
         order = held_labial_ff;
      end else begin
         order = vowel_order(vowel);
      end
   end

   always_comb begin
      result            = '0;
      have_consonant_in = have_consonant_ff;
      last_vowel_in     = last_vowel_ff;
      held_base_in      = held_base_ff;
      held_labial_in    = held_labial_ff;
      if (is_letter) begin
         result.consumed = 1'b1;
         if (vowel == VOWEL_NONE) begin
            have_consonant_in = 1'b1;
            held_base_in      = glyph.base;
            held_labial_in    = glyph.labial;
            last_vowel_in     = VOWEL_NONE;
            result.backspaces = BS_NEW;
            result.code_point = glyph.base + {12'd0, ORDER_CONSONANT};
         end else begin
            have_consonant_in = keep_consonant;
            last_vowel_in     = vowel;
            if (keep_consonant) begin
               result.backspaces = BS_REPLACE;
               result.code_point = held_base_ff + {12'd0, order};
            end else begin
               result.backspaces = BS_NEW;
               result.code_point = glyph.base;
            end
         end
      end else if (key.key_code == KEY_SPACE) begin
         have_consonant_in = 1'b0;
         last_vowel_in     = VOWEL_NONE;
         held_base_in      = '0;
         held_labial_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_consonant_ff <= 1'b0;
         last_vowel_ff     <= VOWEL_NONE;
         held_base_ff      <= '0;
         held_labial_ff    <= '0;
      end else if (fire) begin
         have_consonant_ff <= have_consonant_in;
         last_vowel_ff     <= last_vowel_in;
         held_base_ff      <= held_base_in;
         held_labial_ff    <= held_labial_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ethiopic_transliteration_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// Ethiopic transliteration mapper unit
// Maps Latin key strokes to Ethiopic code points with consonant/vowel history.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one key word (key code and shift state). A word is
// taken at a rising clock edge where req_valid is high and req_stall is low.
// Every key word yields exactly one rsp word: consumed, backspaces and the
// code point, or an all-zero word for keys that are not mapped.
// A taken word sits in the input register while the mapping logic and history
// update run on it; when it fires, the rsp register captures the result and
// rsp_valid rises. One word per cycle is sustained while rsp_stall is low;
// the history registers are updated in the same cycle that reads them, so
// consecutive keys see each other at once.
// When the receiver raises rsp_stall the rsp word holds; the input register
// still drains into the rsp register when that frees, and req_stall rises
// only while both registers are full and the receiver stalls.
// Synchronous reset empties both registers and clears the key history.
// ----------------------------------------------------------------------------
`default_nettype none

module ethiopic_transliteration_mapper_unit #(
   parameter int unsigned LETTER_COUNT = etm_pkg::LETTER_COUNT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_key_code,
   input  wire logic        req_shift_down,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_consumed,
   output logic [1:0]       rsp_backspaces,
   output logic [15:0]      rsp_code_point
);
   import etm_pkg::*;

   logic           key_valid_ff, key_valid_in;
   etm_key_type    key_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   etm_result_type rsp_ff;
   etm_result_type result;
   logic           advance;
   logic           fire;
   logic           req_take;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = key_valid_ff && advance;
   assign req_stall = key_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign key_valid_in = req_take || (key_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   etm_mapper #(
      .LETTER_COUNT(LETTER_COUNT)
   ) u_mapper (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .key   (key_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_valid_ff <= key_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         key_ff.key_code   <= req_key_code;
         key_ff.shift_down <= req_shift_down;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_consumed   = rsp_ff.consumed;
   assign rsp_backspaces = rsp_ff.backspaces;
   assign rsp_code_point = rsp_ff.code_point;

endmodule

`default_nettype wire

@@ sim/ethiopic_transliteration_mapper_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Ethiopic transliteration mapper unit testbench
// Drives key words into the mapper and compares every result word, field by
// field, with a behavioral prediction of the glyph table and the consonant and
// vowel history. Runs a directed set of syllables, then random syllables and
// noise keys under several sender and receiver stall patterns, including a
// long receiver hold-off that backs the pipeline up into the sender.
// ----------------------------------------------------------------------------
module ethiopic_transliteration_mapper_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import etm_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned PHASE_WORDS  = 80;
   localparam int unsigned DRAIN_CYCLES = 4;

   localparam logic [15:0] PLAIN_BASE [26] = '{
      16'h12A0, 16'h1260, 16'h1278, 16'h12F0, 16'h12A5, 16'h1348, 16'h1308,
      16'h1200, 16'h12A2, 16'h1300, 16'h12A8, 16'h1208, 16'h1218, 16'h1290,
      16'h12A6, 16'h1350, 16'h1240, 16'h1228, 16'h1230, 16'h1270, 16'h12A1,
      16'h1268, 16'h12C8, 16'h1238, 16'h12E8, 16'h12D8};
   localparam logic [15:0] SHIFT_BASE [26] = '{
      16'h12A3, 16'h1260, 16'h1328, 16'h12F8, 16'h12A7, 16'h1280, 16'h1318,
      16'h1210, 16'h12A4, 16'h1300, 16'h12B8, 16'h1208, 16'h1218, 16'h1298,
      16'h12A6, 16'h1330, 16'h1250, 16'h1340, 16'h1338, 16'h1320, 16'h12A1,
      16'h1268, 16'h1220, 16'h12D0, 16'h12E8, 16'h12E0};
   localparam logic [3:0] PLAIN_LABIAL [26] = '{
      4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd11, 4'd7, 4'd7, 4'd7, 4'd11, 4'd7,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd11, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
      4'd7, 4'd7};
   localparam logic [3:0] SHIFT_LABIAL [26] = '{
      4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd11, 4'd7, 4'd7, 4'd7, 4'd7, 4'd11, 4'd7,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd11, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
      4'd7, 4'd7};

   class glyph_checker;
      etm_result_type pending_glyphs[$];
      logic           cons_open;
      logic [2:0]     prev_vowel;
      logic [15:0]    kept_base;
      logic [3:0]     kept_labial;
      int unsigned    failures;
      int unsigned    keys_noted;
      int unsigned    replacements;
      int unsigned    spaces;

      function new();
         cons_open    = 1'b0;
         prev_vowel   = VOWEL_NONE;
         kept_base    = '0;
         kept_labial  = '0;
         failures     = 0;
         keys_noted   = 0;
         replacements = 0;
         spaces       = 0;
      endfunction

      function void note_key(logic [7:0] k, logic s);
         etm_result_type r;
         logic [4:0]     row;
         logic [15:0]    base;
         logic [3:0]     lab;
         logic [2:0]     v;
         logic [3:0]     ord;
         logic           pair_ei;
         logic           pair_aa;
         r = '0;
         keys_noted++;
         if (k >= KEY_A && (k - KEY_A) < TABLE_ROWS) begin
            row  = 5'(k - KEY_A);
            base = s ? SHIFT_BASE[row] : PLAIN_BASE[row];
            lab  = s ? SHIFT_LABIAL[row] : PLAIN_LABIAL[row];
            case (k)
               KEY_A:   v = VOWEL_A;
               KEY_E:   v = VOWEL_E;
               KEY_I:   v = VOWEL_I;
               KEY_O:   v = VOWEL_O;
               KEY_U:   v = VOWEL_U;
               default: v = VOWEL_NONE;
            endcase
            r.consumed = 1'b1;
            if (v == VOWEL_NONE) begin
               cons_open    = 1'b1;
               kept_base    = base;
               kept_labial  = lab;
               prev_vowel   = VOWEL_NONE;
               r.backspaces = BS_NEW;
               r.code_point = base + 16'(ORDER_CONSONANT);
            end else begin
               pair_ei = (prev_vowel == VOWEL_E && v == VOWEL_I) ||
                         (prev_vowel == VOWEL_I && v == VOWEL_E);
               pair_aa = (prev_vowel == VOWEL_A && v == VOWEL_A);
               if (prev_vowel != VOWEL_NONE && !pair_ei && !pair_aa) begin
                  cons_open = 1'b0;
               end
               if (!cons_open) begin
                  r.backspaces = BS_NEW;
                  r.code_point = base;
               end else begin
                  if (pair_ei) begin
                     ord = ORDER_PAIR_EI;
                  end else if (pair_aa) begin
                     ord = kept_labial;
                  end else begin
                     case (v)
                        VOWEL_A: ord = 4'd3;
                        VOWEL_E: ord = 4'd0;
                        VOWEL_I: ord = 4'd2;
                        VOWEL_O: ord = 4'd6;
                        default: ord = 4'd1;
                     endcase
                  end
                  r.backspaces = BS_REPLACE;
                  r.code_point = kept_base + 16'(ord);
                  replacements++;
               end
               prev_vowel = v;
            end
         end else if (k == KEY_SPACE) begin
            cons_open   = 1'b0;
            prev_vowel  = VOWEL_NONE;
            kept_base   = '0;
            kept_labial = '0;
            spaces++;
         end
         pending_glyphs.push_back(r);
      endfunction

      function void check_glyph(logic c, logic [1:0] b, logic [15:0] cp);
         etm_result_type want;
         if (pending_glyphs.size() == 0) begin
            failures++;
            $display("%0t: unexpected word consumed=%0d backspaces=%0d code_point=%h",
                     $time, c, b, cp);
            return;
         end
         want = pending_glyphs.pop_front();
         if (c !== want.consumed) begin
            failures++;
            $display("%0t: consumed expected %0d actual %0d", $time, want.consumed, c);
         end
         if (b !== want.backspaces) begin
            failures++;
            $display("%0t: backspaces expected %0d actual %0d",
                     $time, want.backspaces, b);
         end
         if (cp !== want.code_point) begin
            failures++;
            $display("%0t: code_point expected %h actual %h",
                     $time, want.code_point, cp);
         end
      endfunction
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_key_code   = 8'h00;
   logic        req_shift_down = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic        rsp_consumed;
   logic [1:0]  rsp_backspaces;
   logic [15:0] rsp_code_point;

   glyph_checker board = new();

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_len       = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;
   int unsigned cycle_count    = 0;

   ethiopic_transliteration_mapper_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_code   (req_key_code),
      .req_shift_down (req_shift_down),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_consumed   (rsp_consumed),
      .rsp_backspaces (rsp_backspaces),
      .rsp_code_point (rsp_code_point)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("Timed out after %0d cycles.", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         board.check_glyph(rsp_consumed, rsp_backspaces, rsp_code_point);
      end
      if (hold_len != 0 && !hold_done) begin
         hold_left = hold_len;
         hold_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_key(input logic [7:0] k, input logic s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_key_code   <= k;
      req_shift_down <= s;
      do begin
         @(posedge clock);
      end while (req_stall);
      board.note_key(k, s);
   endtask

   task automatic send_random_phase(input int unsigned idle_pct,
                                    input int unsigned stall_pct);
      int unsigned mapped;
      int unsigned pick;
      logic [7:0]  k;
      mapped         = 0;
      send_idle_pct  = idle_pct;
      recv_stall_pct <= stall_pct;
      while (mapped < PHASE_WORDS) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            k = KEY_A + 8'($urandom_range(25));
         end else if (pick < 85) begin
            case ($urandom_range(4))
               0:       k = KEY_A;
               1:       k = KEY_E;
               2:       k = KEY_I;
               3:       k = KEY_O;
               default: k = KEY_U;
            endcase
         end else if (pick < 92) begin
            k = KEY_SPACE;
         end else begin
            k = 8'($urandom_range(255));
         end
         if (k == KEY_SPACE || (k >= KEY_A && (k - KEY_A) < TABLE_ROWS)) begin
            mapped++;
         end
         send_key(k, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_key(8'h00, 1'b0);
      send_key(8'hFF, 1'b1);
      send_key(KEY_SPACE, 1'b1);
      send_key(KEY_A, 1'b0);
      send_key(KEY_A, 1'b0);
      send_key(8'h42, 1'b0);
      send_key(KEY_A, 1'b0);
      send_key(KEY_A, 1'b0);
      send_key(8'h4B, 1'b1);
      send_key(KEY_A, 1'b1);
      send_key(KEY_A, 1'b0);
      send_key(8'h47, 1'b0);
      send_key(KEY_E, 1'b0);
      send_key(KEY_I, 1'b1);
      send_key(8'h5A, 1'b1);
      send_key(KEY_I, 1'b0);
      send_key(KEY_E, 1'b0);
      send_key(8'h46, 1'b1);
      send_key(KEY_O, 1'b0);
      send_key(KEY_U, 1'b0);
      send_key(8'h54, 1'b0);
      send_key(KEY_U, 1'b1);
      send_key(8'h5B, 1'b0);
      send_key(8'h40, 1'b1);
      send_key(KEY_SPACE, 1'b0);
      send_key(KEY_E, 1'b1);

      send_random_phase(0, 0);
      send_random_phase(86, 0);
      send_random_phase(0, 86);
      hold_len <= 60;
      send_random_phase(0, 0);
      send_random_phase(18, 18);
      req_valid <= 1'b0;

      while (board.pending_glyphs.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.failures += board.pending_glyphs.size();

      $display("Sent %0d key words: %0d syllable replacements and %0d spaces,",
               board.keys_noted, board.replacements, board.spaces);
      $display("under free flow, sender gaps, receiver stalls, a long hold-off and mixed.");
      if (board.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/etm_pkg.sv
sv/etm_mapper.sv
sv/ethiopic_transliteration_mapper_unit.sv
sim/ethiopic_transliteration_mapper_unit_tb.sv
